// File: rtl/afgs_pkg.sv
// ----------------------------------------------------------------------------
// afgs_pkg
// Shared types and constants for the alternating free group search block.
// ----------------------------------------------------------------------------
package afgs_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_GROUP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_GROUP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_PER_TRACK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_CODE      = 3'd3;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    localparam logic [7:0] RST_START_GROUP      = 8'd37;
    localparam logic [7:0] RST_LAST_GROUP       = 8'd79;
    localparam logic [4:0] RST_GROUPS_PER_TRACK = 5'd2;
    localparam logic [7:0] RST_UNUSED_CODE      = 8'd255;

    // candidate arithmetic width, signed
    localparam int CAND_W  = 13;
    // distance to the current track pair
    localparam int DIST_W  = 10;
    // candidate counter, holds twice the widest range
    localparam int COUNT_W = 9;

    typedef struct packed {
        logic       kind;
        logic [7:0] entry_index;
        logic [7:0] entry_value;
    } req_item_t;

    typedef struct packed {
        logic       found;
        logic [7:0] free_group;
    } rsp_item_t;

    typedef struct packed {
        logic [7:0] start_group;
        logic [7:0] last_group;
        logic [4:0] groups_per_track;
        logic [7:0] unused_code;
    } cfg_t;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic       found;
        logic [7:0] group;
    } srch_status_t;

    typedef enum logic {
        SRCH_IDLE,
        SRCH_SCAN
    } srch_state_t;

endpackage

// File: rtl/afgs_table.sv
// ----------------------------------------------------------------------------
// afgs_table
// Allocation table memory with one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module afgs_table #(
    parameter int DEPTH = 256,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : 8'd0;

endmodule

// File: rtl/afgs_search.sv
// ----------------------------------------------------------------------------
// afgs_search
// Search sequencer: walks the alternating candidate order, issues one table
// read per cycle and compares the returned entry in the next cycle.
// ----------------------------------------------------------------------------
module afgs_search #(
    parameter int DEPTH = 256,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  afgs_pkg::cfg_t        cfg,
    input  logic [7:0]            rd_data,
    output logic [IDX_W-1:0]      rd_addr,
    output afgs_pkg::srch_status_t status
);

    localparam int CW = afgs_pkg::CAND_W;
    localparam int DW = afgs_pkg::DIST_W;
    localparam int NW = afgs_pkg::COUNT_W;

    afgs_pkg::srch_state_t state_reg, state_next;

    logic [NW-1:0] count_reg, count_next;
    logic [NW-1:0] span_reg, span_next;
    logic [4:0]    gpt_reg, gpt_next;
    logic [4:0]    offs_reg, offs_next;
    logic [DW-1:0] dist_reg, dist_next;
    logic          above_reg, above_next;
    logic          pend_reg, pend_next;
    logic [7:0]    cand_reg, cand_next;

    logic [4:0]    gpt_eff;
    logic [7:0]    diff;
    logic [7:0]    reach;
    logic [CW-1:0] cand;
    logic          cand_ok;
    logic          hit;

    assign gpt_eff = (cfg.groups_per_track == 5'd0) ? 5'd1 : cfg.groups_per_track;
    assign diff    = (cfg.last_group > cfg.start_group) ?
                     (cfg.last_group - cfg.start_group) : 8'd0;
    assign reach   = (diff > cfg.start_group) ? diff : cfg.start_group;

    always_comb
    begin
        if (above_reg)
        begin
            cand = CW'(cfg.start_group) + CW'(dist_reg) + CW'(offs_reg);
        end
        else
        begin
            cand = CW'(cfg.start_group) + CW'(offs_reg) - CW'(dist_reg);
        end
    end

    assign cand_ok = !cand[CW-1]
                     && (cand <= CW'(cfg.last_group))
                     && (cand < CW'(DEPTH));
    assign rd_addr = cand[IDX_W-1:0];
    assign hit     = pend_reg && (rd_data == cfg.unused_code);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= afgs_pkg::SRCH_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        span_reg  <= span_next;
        gpt_reg   <= gpt_next;
        offs_reg  <= offs_next;
        dist_reg  <= dist_next;
        above_reg <= above_next;
        cand_reg  <= cand_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        span_next    = span_reg;
        gpt_next     = gpt_reg;
        offs_next    = offs_reg;
        dist_next    = dist_reg;
        above_next   = above_reg;
        pend_next    = 1'b0;
        cand_next    = cand_reg;
        status.busy  = 1'b0;
        status.done  = 1'b0;
        status.found = 1'b0;
        status.group = 8'd0;

        unique case (state_reg)
            afgs_pkg::SRCH_IDLE:
            begin
                if (start)
                begin
                    state_next = afgs_pkg::SRCH_SCAN;
                    count_next = '0;
                    span_next  = {reach, 1'b0};
                    gpt_next   = gpt_eff;
                    offs_next  = 5'd0;
                    dist_next  = DW'(gpt_eff);
                    above_next = 1'b0;
                end
            end
            afgs_pkg::SRCH_SCAN:
            begin
                status.busy = 1'b1;
                if (hit)
                begin
                    status.done  = 1'b1;
                    status.found = 1'b1;
                    status.group = cand_reg;
                    state_next   = afgs_pkg::SRCH_IDLE;
                end
                else if (count_reg == span_reg)
                begin
                    status.done = 1'b1;
                    state_next  = afgs_pkg::SRCH_IDLE;
                end
                else
                begin
                    // issue the next candidate, compare lands in the next cycle
                    pend_next  = cand_ok;
                    cand_next  = cand[7:0];
                    count_next = count_reg + NW'(1);
                    if (offs_reg + 5'd1 == gpt_reg)
                    begin
                        offs_next  = 5'd0;
                        above_next = !above_reg;
                        if (above_reg)
                        begin
                            dist_next = dist_reg + DW'(gpt_reg);
                        end
                    end
                    else
                    begin
                        offs_next = offs_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = afgs_pkg::SRCH_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/alternating_free_group_search.sv
// ----------------------------------------------------------------------------
// alternating_free_group_search
// Allocation table with a free group search that alternates below and above
// the management area, one track's worth of groups at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries write and search items.
//   rsp channel (rsp_valid/rsp_stall/rsp) returns one item per request.
//   cfg_we/cfg_index/cfg_data write the four registers while the block idles.
// Latency:
//   a write item updates the table and its result shows the next cycle.
//   a search item reads one table entry per cycle from the single read port
//   and ends early on a hit.
// Throughput:
//   one item at a time; a new item is taken once the search is over and the
//   result register is empty or being emptied in the same cycle.
// Reset:
//   registers return to their defaults, the table reads as all zero through
//   per-entry valid bits, no clearing pass is needed.
// Stall:
//   a held result stays in the result register and stalls further requests.
// ----------------------------------------------------------------------------
module alternating_free_group_search #(
    parameter int MAX_GROUPS = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  afgs_pkg::req_item_t                  req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output afgs_pkg::rsp_item_t                  rsp,
    input  logic                                 cfg_we,
    input  logic [afgs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [7:0]                           cfg_data
);

    localparam int IDX_W = $clog2(MAX_GROUPS);

    afgs_pkg::cfg_t        cfg_reg;
    afgs_pkg::rsp_item_t   rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    afgs_pkg::srch_status_t srch;

    logic             req_accept;
    logic             is_write;
    logic             srch_start;
    logic             tbl_wr_en;
    logic [IDX_W-1:0] tbl_rd_addr;
    logic [7:0]       tbl_rd_data;

    assign req_stall  = srch.busy || (rsp_valid_reg && rsp_stall);
    assign req_accept = req_valid && !req_stall;
    assign is_write   = (req.kind == afgs_pkg::KIND_WRITE);
    assign srch_start = req_accept && (req.kind == afgs_pkg::KIND_SEARCH);
    assign tbl_wr_en  = req_accept && is_write
                        && ({1'b0, req.entry_index} < 9'(MAX_GROUPS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_group      <= afgs_pkg::RST_START_GROUP;
            cfg_reg.last_group       <= afgs_pkg::RST_LAST_GROUP;
            cfg_reg.groups_per_track <= afgs_pkg::RST_GROUPS_PER_TRACK;
            cfg_reg.unused_code      <= afgs_pkg::RST_UNUSED_CODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                afgs_pkg::CFG_START_GROUP:      cfg_reg.start_group      <= cfg_data;
                afgs_pkg::CFG_LAST_GROUP:       cfg_reg.last_group       <= cfg_data;
                afgs_pkg::CFG_GROUPS_PER_TRACK: cfg_reg.groups_per_track <= cfg_data[4:0];
                afgs_pkg::CFG_UNUSED_CODE:      cfg_reg.unused_code      <= cfg_data;
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (req_accept && is_write)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.found      = 1'b0;
            rsp_next.free_group = 8'd0;
        end
        else if (srch.done)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.found      = srch.found;
            rsp_next.free_group = srch.group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    afgs_table #(
        .DEPTH (MAX_GROUPS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (req.entry_index[IDX_W-1:0]),
        .wr_data (req.entry_value),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    afgs_search #(
        .DEPTH (MAX_GROUPS),
        .IDX_W (IDX_W)
    ) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (srch_start),
        .cfg     (cfg_reg),
        .rd_data (tbl_rd_data),
        .rd_addr (tbl_rd_addr),
        .status  (srch)
    );

endmodule

// File: rtl/afgs_checker.sv
// ----------------------------------------------------------------------------
// afgs_checker
// Port-level checks for the alternating free group search block.
// ----------------------------------------------------------------------------
module afgs_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_stall,
    input afgs_pkg::req_item_t  req,
    input logic                 rsp_valid,
    input logic                 rsp_stall,
    input afgs_pkg::rsp_item_t  rsp
);

    // held item stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result item changed");

    // no group reported without a hit
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.free_group == 8'd0)
        else $error("miss item carries a group");

    // write item answers on the next cycle with found clear
    a_write_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.kind == afgs_pkg::KIND_WRITE
        |=> rsp_valid && !rsp.found)
        else $error("write item result missing or wrong");

    // a search holds off further items
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.kind == afgs_pkg::KIND_SEARCH
        |=> req_stall && !rsp_valid)
        else $error("item taken during search");

endmodule

bind alternating_free_group_search afgs_checker u_afgs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// File: tb/sv/alternating_free_group_search_tb.sv
// ----------------------------------------------------------------------------
// alternating_free_group_search_tb
// Self-checking bench for the allocation table and its alternating free group
// search. A short table of hand-picked items runs first, then phases of random
// write and search items under several register settings, the extremes among
// them. Each answer is a row's given one or predicted from a private copy of the
// table and registers; each returned item is checked field by field in order.
// ----------------------------------------------------------------------------
module alternating_free_group_search_tb;

    import afgs_pkg::*;

    localparam int CYCLE_LIMIT   = 3000000;
    localparam int SETTLE_CYCLES = 520;
    localparam int DIRECTED_ROWS = 24;
    localparam int PRESET_PHASES = 5;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 115;

    typedef struct packed {
        logic       kind;
        logic [7:0] entry_index;
        logic [7:0] entry_value;
        logic       given;
        logic       found;
        logic [7:0] free_group;
    } directed_row_t;

    // start group, last group, groups per track, unused code
    localparam logic [31:0] PRESET_SETTINGS [0:PRESET_PHASES-1] = '{
        32'h00_FF_01_00,
        32'hFF_00_10_FF,
        32'h00_00_00_5A,
        32'h80_FF_FF_AA,
        32'hFF_FF_03_01
    };

    localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{KIND_SEARCH, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00},
        '{KIND_SEARCH, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00},
        '{KIND_WRITE,  8'h00, 8'h00, 1'b1, 1'b0, 8'h00},
        '{KIND_WRITE,  8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00},
        '{KIND_WRITE,  8'h26, 8'hFF, 1'b1, 1'b0, 8'h00},
        '{KIND_WRITE,  8'h25, 8'hFF, 1'b1, 1'b0, 8'h00},
        '{KIND_SEARCH, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{KIND_WRITE,  8'h4F, 8'hFF, 1'b1, 1'b0, 8'h00},
        '{KIND_SEARCH, 8'h5A, 8'hA5, 1'b0, 1'b0, 8'h00},
        '{KIND_WRITE,  8'h00, 8'hFF, 1'b1, 1'b0, 8'h00},
        '{KIND_SEARCH, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{KIND_WRITE,  8'h27, 8'hFF, 1'b1, 1'b0, 8'h00},
        '{KIND_SEARCH, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{KIND_WRITE,  8'h24, 8'hFF, 1'b1, 1'b0, 8'h00},
        '{KIND_SEARCH, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{KIND_WRITE,  8'h24, 8'h00, 1'b1, 1'b0, 8'h00},
        '{KIND_WRITE,  8'h27, 8'h5A, 1'b1, 1'b0, 8'h00},
        '{KIND_SEARCH, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{KIND_WRITE,  8'h80, 8'hA5, 1'b1, 1'b0, 8'h00},
        '{KIND_WRITE,  8'h7F, 8'h5A, 1'b1, 1'b0, 8'h00},
        '{KIND_WRITE,  8'h00, 8'h00, 1'b1, 1'b0, 8'h00},
        '{KIND_SEARCH, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{KIND_WRITE,  8'h4F, 8'h00, 1'b1, 1'b0, 8'h00},
        '{KIND_SEARCH, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    req_item_t            req;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_item_t            rsp;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    logic [7:0]  alloc_image [0:255];
    cfg_t        cfg_image;
    rsp_item_t   answers_q [$];
    rsp_item_t   oldest_answer;

    int error_count    = 0;
    int cycle_count    = 0;
    int items_sent     = 0;
    int searches_sent  = 0;
    int hits_predicted = 0;
    int results_seen   = 0;
    int settings_used  = 0;
    int burst_left     = 0;
    int stall_mode     = 0;
    int stall_left     = 0;

    alternating_free_group_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // updates the table copy on a write and scans for a free group on a search
    function automatic rsp_item_t predict_item(input req_item_t it);
        rsp_item_t ans;
        int g;
        int s;
        int e;
        int d;
        int m;
        int blk;
        int pair_no;
        int off;
        int cand;
        ans = '0;
        if (it.kind == KIND_WRITE)
        begin
            alloc_image[it.entry_index] = it.entry_value;
            return ans;
        end
        g = (cfg_image.groups_per_track == 5'd0) ? 1 : int'(cfg_image.groups_per_track);
        s = int'(cfg_image.start_group);
        e = int'(cfg_image.last_group);
        d = (e > s) ? e - s : 0;
        m = (d > s) ? d : s;
        for (int i = 0; i < 2 * m && !ans.found; i++)
        begin
            blk     = i / g;
            pair_no = i / (2 * g);
            off     = i % g;
            if ((blk & 1) == 0)
                cand = s - (pair_no + 1) * g + off;
            else
                cand = s + (pair_no + 1) * g + off;
            if (cand >= 0 && cand <= e && cand < 256)
            begin
                if (alloc_image[cand] == cfg_image.unused_code)
                begin
                    ans.found      = 1'b1;
                    ans.free_group = cand[7:0];
                end
            end
        end
        return ans;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_START_GROUP:      cfg_image.start_group      = data;
            CFG_LAST_GROUP:       cfg_image.last_group       = data;
            CFG_GROUPS_PER_TRACK: cfg_image.groups_per_track = data[4:0];
            CFG_UNUSED_CODE:      cfg_image.unused_code      = data;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [31:0] word);
        logic [CFG_IDX_W-1:0] stray_idx;
        stray_idx = CFG_IDX_W'($urandom_range(7, 4));
        write_reg(CFG_START_GROUP,      word[31:24]);
        write_reg(CFG_LAST_GROUP,       word[23:16]);
        write_reg(CFG_GROUPS_PER_TRACK, word[15:8]);
        write_reg(CFG_UNUSED_CODE,      word[7:0]);
        write_reg(stray_idx, 8'($urandom_range(255, 0)));
        settings_used++;
    endtask

    task automatic wait_drained;
        @(negedge clk);
        req_valid <= 1'b0;
        burst_left = 0;
        while (answers_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_item(input req_item_t it, input logic given,
                             input rsp_item_t given_ans);
        int gap;
        rsp_item_t ans;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20)
                                                      : $urandom_range(12, 1);
            if ($urandom_range(3, 0) != 0)
                gap = $urandom_range(12, 1);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (req_stall);
        ans = predict_item(it);
        items_sent++;
        if (it.kind == KIND_SEARCH)
        begin
            searches_sent++;
            if (ans.found)
                hits_predicted++;
        end
        answers_q.push_back(given ? given_ans : ans);
    endtask

    function automatic req_item_t make_random_item(input int search_pct);
        req_item_t it;
        int near_idx;
        it.entry_index = 8'($urandom_range(255, 0));
        it.entry_value = 8'($urandom_range(255, 0));
        it.kind = (int'($urandom_range(99, 0)) < search_pct) ? KIND_SEARCH : KIND_WRITE;
        if (it.kind == KIND_WRITE)
        begin
            if ($urandom_range(1, 0) == 1)
            begin
                near_idx = int'(cfg_image.start_group) + int'($urandom_range(48, 0)) - 24;
                if (near_idx < 0)
                    near_idx = 0;
                if (near_idx > 255)
                    near_idx = 255;
                it.entry_index = near_idx[7:0];
            end
            if ($urandom_range(2, 0) == 0)
                it.entry_value = cfg_image.unused_code;
        end
        return it;
    endfunction

    function automatic logic [31:0] random_settings;
        logic [7:0] sg;
        logic [7:0] lg;
        logic [7:0] gp;
        sg = 8'($urandom_range(255, 0));
        if ($urandom_range(9, 0) < 7)
            lg = 8'($urandom_range(255, int'(sg)));
        else
            lg = 8'($urandom_range(255, 0));
        if ($urandom_range(4, 0) == 0)
            gp = 8'($urandom_range(255, 0));
        else
            gp = 8'($urandom_range(16, 1));
        return {sg, lg, gp, 8'($urandom_range(255, 0))};
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (answers_q.size() == 0)
                report_mismatch("result with nothing pending, group", rsp.free_group, -1);
            else
            begin
                oldest_answer = answers_q.pop_front();
                if (rsp.found !== oldest_answer.found)
                    report_mismatch("found", rsp.found, oldest_answer.found);
                if (rsp.free_group !== oldest_answer.free_group)
                    report_mismatch("free_group", rsp.free_group, oldest_answer.free_group);
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(2, 0);
            stall_left = $urandom_range(200, 20);
        end
        stall_left--;
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(3, 0) == 0);
            default: rsp_stall <= ((cycle_count % 7) < 3);
        endcase
    end

    initial
    begin
        req_item_t     it;
        rsp_item_t     typed_ans;
        directed_row_t row;
        int            search_pct;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        for (int n = 0; n < 256; n++)
            alloc_image[n] = 8'h00;
        cfg_image.start_group      = RST_START_GROUP;
        cfg_image.last_group       = RST_LAST_GROUP;
        cfg_image.groups_per_track = RST_GROUPS_PER_TRACK;
        cfg_image.unused_code      = RST_UNUSED_CODE;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        for (int n = 0; n < DIRECTED_ROWS; n++)
        begin
            row                  = DIRECTED[n];
            it.kind              = row.kind;
            it.entry_index       = row.entry_index;
            it.entry_value       = row.entry_value;
            typed_ans.found      = row.found;
            typed_ans.free_group = row.free_group;
            send_item(it, row.given, typed_ans);
        end

        for (int ph = 0; ph < PRESET_PHASES + RANDOM_PHASES; ph++)
        begin
            wait_drained;
            if (ph < PRESET_PHASES)
                load_settings(PRESET_SETTINGS[ph]);
            else
                load_settings(random_settings());
            search_pct = $urandom_range(45, 25);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99, 0) == 0)
                    wait_drained;
                send_item(make_random_item(search_pct), 1'b0, '0);
            end
        end

        wait_drained;
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("%0d items (%0d searches, %0d expected hits) over %0d register settings",
                 items_sent, searches_sent, hits_predicted, settings_used);
        $display("%0d results checked in %0d cycles, %0d mismatches",
                 results_seen, cycle_count, error_count);
        if (error_count == 0 && answers_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
